### sv/tpsa_pkg.sv
// Shared widths, constants, stage types and the arctangent table function.
`default_nettype none
package tpsa_pkg;

  // Field and datapath widths
  localparam int COORD_BITS      = 24;
  localparam int DIF_W           = COORD_BITS + 1;      // coordinate difference
  localparam int PRD_W           = 2 * DIF_W;           // product of two differences
  localparam int SQ_W            = PRD_W;               // squared side length
  localparam int X_W             = PRD_W + 1;           // doubled signed area
  localparam int DD_W            = X_W;                 // 2*|X|
  localparam int HALF_W          = (SQ_W + 1) / 2;      // multiplier slice width
  localparam int AB_W            = 2 * SQ_W;            // a2*b2
  localparam int P_W             = 3 * SQ_W - 2;        // a2*b2*c2, even width
  localparam int S_W             = P_W / 2;             // floor(sqrt(p))
  localparam int R_W             = 31;                  // radius magnitude
  localparam int DR_W            = DD_W + R_W;          // divider remainder
  localparam int CORDIC_STEPS    = 32;
  localparam int CORDIC_PRESHIFT = 24;
  localparam int CX_W            = R_W + CORDIC_PRESHIFT + 3;
  localparam int Z_W             = 34;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ANG_W           = 16;
  localparam int RAD_W           = 32;
  localparam int WB_W            = 16;

  localparam int ANG_FULL  = 90 << ANGLE_FRAC_BITS;
  localparam int ANG_LIM   = (ANG_FULL < 32767) ? ANG_FULL : 32767;
  localparam int ANG_SHIFT = 56 - ANGLE_FRAC_BITS;
  localparam logic signed [63:0] ANG_RND = 64'sd1 <<< (55 - ANGLE_FRAC_BITS);
  localparam logic signed [63:0] DEG_PER_RAD_Q24 = 64'sd961263669;

  localparam logic [RAD_W-1:0] RADIUS_MAX      = 32'h7FFF_FFFF;
  localparam logic [WB_W-1:0]  WHEELBASE_RESET = 16'd2570;

  // Register index decode
  localparam logic REG_WHEELBASE = 1'b0;

  typedef struct packed {
    logic [P_W-1:0]  p;
    logic [DD_W-1:0] dd;
    logic            neg;
    logic            straight;
  } geom_t;

  typedef struct packed {
    logic [S_W-1:0]  s;
    logic [DD_W-1:0] dd;
    logic            neg;
    logic            straight;
  } root_t;

  typedef struct packed {
    logic [R_W-1:0] r;
    logic           neg;
    logic           straight;
    logic           clip;
  } rad_t;

  typedef struct packed {
    logic signed [RAD_W-1:0] turn_radius;
    logic signed [ANG_W-1:0] steer_angle;
    logic                    straight;
    logic                    clip;
  } result_t;

  // floor(2^e / d) by shift and subtract, elaboration only
  function automatic logic [63:0] pow2_div(input int e, input int d);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], (b == e)};
      if (rem >= 64'(d)) begin
        rem  = rem - 64'(d);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q32 radians from the Q62 series, rounded half up
  function automatic logic [63:0] atan_q32(input int i);
    logic [63:0] sum;
    int          e;
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e >= 0) begin
        if (k[0]) sum = sum - pow2_div(e, 2 * k + 1);
        else      sum = sum + pow2_div(e, 2 * k + 1);
      end
    end
    return (sum + 64'd536870912) >> 30;
  endfunction

endpackage
`default_nettype wire

### sv/tpsa_geom.sv
// Geometry front end: signed doubled area and product of squared side lengths.
`default_nettype none
module tpsa_geom (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [tpsa_pkg::COORD_BITS-1:0] ax,
  input  logic signed [tpsa_pkg::COORD_BITS-1:0] ay,
  input  logic signed [tpsa_pkg::COORD_BITS-1:0] bx,
  input  logic signed [tpsa_pkg::COORD_BITS-1:0] by,
  input  logic signed [tpsa_pkg::COORD_BITS-1:0] cx,
  input  logic signed [tpsa_pkg::COORD_BITS-1:0] cy,
  output logic                                 out_valid,
  output tpsa_pkg::geom_t                      out_geom
);

  localparam int H   = tpsa_pkg::HALF_W;
  localparam int Q_W = tpsa_pkg::AB_W + H;

  typedef struct packed {
    logic [tpsa_pkg::DD_W-1:0] dd;
    logic                      neg;
    logic                      straight;
  } side_t;

  logic [7:1] v_r;

  // stage 1: differences
  logic signed [tpsa_pkg::DIF_W-1:0] d1x_r, d1y_r, d2x_r, d2y_r, abx_r, aby_r;
  // stage 2: area products and squared sides
  logic signed [tpsa_pkg::PRD_W-1:0] m1_r, m2_r;
  logic [tpsa_pkg::SQ_W-1:0]         a2_r, b2_r, c2_r;
  // stage 3: area, first partial products
  logic signed [tpsa_pkg::X_W-1:0]   x_nxt;
  logic [tpsa_pkg::X_W-1:0]          xm_nxt;
  side_t                             side3_r, side4_r, side5_r, side6_r, side7_r;
  logic [2*H-1:0]                    pp_r [4];
  logic [tpsa_pkg::SQ_W-1:0]         c2_3_r, c2_4_r;
  // stage 4..7
  logic [tpsa_pkg::AB_W-1:0]         ab_r;
  logic [2*H-1:0]                    pq_r [8];
  logic [Q_W-1:0]                    q_nxt [2];
  logic [Q_W-1:0]                    q_r [2];
  logic [tpsa_pkg::P_W-1:0]          p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:1], in_valid};
    end
  end

  assign x_nxt  = tpsa_pkg::X_W'(m1_r) - tpsa_pkg::X_W'(m2_r);
  assign xm_nxt = x_nxt[tpsa_pkg::X_W-1] ? -x_nxt : x_nxt;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      q_nxt[k] = '0;
      for (int j = 0; j < 4; j++) begin
        q_nxt[k] = q_nxt[k] + (Q_W'(pq_r[j*2+k]) << (H * j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1x_r <= tpsa_pkg::DIF_W'(ax) - tpsa_pkg::DIF_W'(cx);
      d1y_r <= tpsa_pkg::DIF_W'(ay) - tpsa_pkg::DIF_W'(cy);
      d2x_r <= tpsa_pkg::DIF_W'(bx) - tpsa_pkg::DIF_W'(cx);
      d2y_r <= tpsa_pkg::DIF_W'(by) - tpsa_pkg::DIF_W'(cy);
      abx_r <= tpsa_pkg::DIF_W'(ax) - tpsa_pkg::DIF_W'(bx);
      aby_r <= tpsa_pkg::DIF_W'(ay) - tpsa_pkg::DIF_W'(by);

      m1_r <= tpsa_pkg::PRD_W'(d1x_r) * tpsa_pkg::PRD_W'(d2y_r);
      m2_r <= tpsa_pkg::PRD_W'(d2x_r) * tpsa_pkg::PRD_W'(d1y_r);
      a2_r <= tpsa_pkg::SQ_W'(tpsa_pkg::PRD_W'(abx_r) * tpsa_pkg::PRD_W'(abx_r)
                            + tpsa_pkg::PRD_W'(aby_r) * tpsa_pkg::PRD_W'(aby_r));
      b2_r <= tpsa_pkg::SQ_W'(tpsa_pkg::PRD_W'(d1x_r) * tpsa_pkg::PRD_W'(d1x_r)
                            + tpsa_pkg::PRD_W'(d1y_r) * tpsa_pkg::PRD_W'(d1y_r));
      c2_r <= tpsa_pkg::SQ_W'(tpsa_pkg::PRD_W'(d2x_r) * tpsa_pkg::PRD_W'(d2x_r)
                            + tpsa_pkg::PRD_W'(d2y_r) * tpsa_pkg::PRD_W'(d2y_r));

      side3_r.dd       <= tpsa_pkg::DD_W'({xm_nxt[tpsa_pkg::X_W-2:0], 1'b0});
      side3_r.neg      <= x_nxt[tpsa_pkg::X_W-1];
      side3_r.straight <= (m1_r == m2_r);
      pp_r[0] <= (2*H)'(a2_r[H-1:0])   * (2*H)'(b2_r[H-1:0]);
      pp_r[1] <= (2*H)'(a2_r[H-1:0])   * (2*H)'(b2_r[2*H-1:H]);
      pp_r[2] <= (2*H)'(a2_r[2*H-1:H]) * (2*H)'(b2_r[H-1:0]);
      pp_r[3] <= (2*H)'(a2_r[2*H-1:H]) * (2*H)'(b2_r[2*H-1:H]);
      c2_3_r  <= c2_r;

      ab_r    <= tpsa_pkg::AB_W'(pp_r[0])
               + (tpsa_pkg::AB_W'(pp_r[1]) << H)
               + (tpsa_pkg::AB_W'(pp_r[2]) << H)
               + (tpsa_pkg::AB_W'(pp_r[3]) << (2 * H));
      c2_4_r  <= c2_3_r;
      side4_r <= side3_r;

      for (int j = 0; j < 4; j++) begin
        pq_r[j*2]   <= (2*H)'(ab_r[H*j +: H]) * (2*H)'(c2_4_r[H-1:0]);
        pq_r[j*2+1] <= (2*H)'(ab_r[H*j +: H]) * (2*H)'(c2_4_r[2*H-1:H]);
      end
      side5_r <= side4_r;

      q_r[0]  <= q_nxt[0];
      q_r[1]  <= q_nxt[1];
      side6_r <= side5_r;

      p_r     <= tpsa_pkg::P_W'(q_r[0]) + (tpsa_pkg::P_W'(q_r[1]) << H);
      side7_r <= side6_r;
    end
  end

  assign out_valid         = v_r[7];
  assign out_geom.p        = p_r;
  assign out_geom.dd       = side7_r.dd;
  assign out_geom.neg      = side7_r.neg;
  assign out_geom.straight = side7_r.straight;

endmodule
`default_nettype wire

### sv/tpsa_sqrt.sv
// Pipelined restoring integer square root, one root bit per stage.
`default_nettype none
module tpsa_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  tpsa_pkg::geom_t in_geom,
  output logic            out_valid,
  output tpsa_pkg::root_t out_root
);

  localparam int S_W = tpsa_pkg::S_W;
  localparam int P_W = tpsa_pkg::P_W;

  typedef struct packed {
    logic [P_W-1:0]            pbits;
    logic [S_W+1:0]            rem;
    logic [S_W-1:0]            root;
    logic [tpsa_pkg::DD_W-1:0] dd;
    logic                      neg;
    logic                      straight;
  } sq_stage_t;

  logic      v_r  [S_W];
  sq_stage_t sq_r [S_W];

  for (genvar k = 0; k < S_W; k++) begin : g_stage
    sq_stage_t      src, nxt;
    logic           vsrc;
    logic [S_W+1:0] rem_sh, trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign vsrc         = in_valid;
      assign src.pbits    = in_geom.p;
      assign src.rem      = '0;
      assign src.root     = '0;
      assign src.dd       = in_geom.dd;
      assign src.neg      = in_geom.neg;
      assign src.straight = in_geom.straight;
    end else begin : g_next
      assign vsrc = v_r[k-1];
      assign src  = sq_r[k-1];
    end

    always_comb begin
      rem_sh    = {src.rem[S_W-1:0], src.pbits[P_W-1 -: 2]};
      trial     = {src.root, 2'b01};
      ge        = (rem_sh >= trial);
      nxt       = src;
      nxt.pbits = src.pbits << 2;
      nxt.rem   = ge ? (rem_sh - trial) : rem_sh;
      nxt.root  = {src.root[S_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vsrc;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k] <= nxt;
      end
    end
  end

  assign out_valid         = v_r[S_W-1];
  assign out_root.s        = sq_r[S_W-1].root;
  assign out_root.dd       = sq_r[S_W-1].dd;
  assign out_root.neg      = sq_r[S_W-1].neg;
  assign out_root.straight = sq_r[S_W-1].straight;

endmodule
`default_nettype wire

### sv/tpsa_div.sv
// Pipelined restoring divider: radius = floor(root / 2|X|) with saturation.
`default_nettype none
module tpsa_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  tpsa_pkg::root_t in_root,
  output logic            out_valid,
  output tpsa_pkg::rad_t  out_rad
);

  localparam int R_W  = tpsa_pkg::R_W;
  localparam int DR_W = tpsa_pkg::DR_W;
  localparam int N    = R_W + 1;

  typedef struct packed {
    logic [DR_W-1:0]           rem;
    logic [R_W-1:0]            q;
    logic [tpsa_pkg::DD_W-1:0] dd;
    logic                      neg;
    logic                      straight;
    logic                      clip;
  } dv_stage_t;

  logic      v_r  [N];
  dv_stage_t dv_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    dv_stage_t       src, nxt;
    logic            vsrc;
    logic [DR_W-1:0] trial;

    if (k == 0) begin : g_first
      // quotient would need more than R_W bits: saturate
      assign vsrc         = in_valid;
      assign src.rem      = DR_W'(in_root.s);
      assign src.q        = '0;
      assign src.dd       = in_root.dd;
      assign src.neg      = in_root.neg;
      assign src.straight = in_root.straight;
      assign src.clip     = 1'b0;
      assign trial        = DR_W'(in_root.dd) << R_W;
      always_comb begin
        nxt      = src;
        nxt.clip = (src.rem >= trial);
      end
    end else begin : g_next
      assign vsrc  = v_r[k-1];
      assign src   = dv_r[k-1];
      assign trial = DR_W'(src.dd) << (R_W - k);
      always_comb begin
        nxt = src;
        if (src.rem >= trial) begin
          nxt.rem        = src.rem - trial;
          nxt.q[R_W - k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vsrc;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k] <= nxt;
      end
    end
  end

  assign out_valid        = v_r[N-1];
  assign out_rad.r        = dv_r[N-1].clip ? tpsa_pkg::RADIUS_MAX[R_W-1:0] : dv_r[N-1].q;
  assign out_rad.neg      = dv_r[N-1].neg;
  assign out_rad.straight = dv_r[N-1].straight;
  assign out_rad.clip     = dv_r[N-1].clip;

endmodule
`default_nettype wire

### sv/tpsa_cordic.sv
// Vectoring CORDIC arctangent of wheelbase over radius, scaled to degrees.
`default_nettype none
module tpsa_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  tpsa_pkg::rad_t                in_rad,
  input  logic [tpsa_pkg::WB_W-1:0]     wheelbase,
  output logic                          out_valid,
  output tpsa_pkg::result_t             out_res
);

  localparam int CX_W = tpsa_pkg::CX_W;
  localparam int Z_W  = tpsa_pkg::Z_W;
  localparam int R_W  = tpsa_pkg::R_W;
  localparam int NS   = tpsa_pkg::CORDIC_STEPS;

  typedef struct packed {
    logic [R_W-1:0] r;
    logic           neg;
    logic           straight;
    logic           clip;
    logic           swap;
    logic           zl;
    logic           zr;
  } flags_t;

  typedef struct packed {
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    logic signed [Z_W-1:0]  z;
    flags_t                 fl;
  } cd_stage_t;

  logic      v_r  [NS+1];
  cd_stage_t cd_r [NS+1];

  // entry: order the pair so that x >= y
  logic           swap;
  logic [R_W-1:0] big, lit;
  cd_stage_t      entry;

  assign swap = (R_W'(wheelbase) > in_rad.r);
  assign big  = swap ? R_W'(wheelbase) : in_rad.r;
  assign lit  = swap ? in_rad.r : R_W'(wheelbase);

  always_comb begin
    entry.xs          = CX_W'({big, {tpsa_pkg::CORDIC_PRESHIFT{1'b0}}});
    entry.ys          = CX_W'({lit, {tpsa_pkg::CORDIC_PRESHIFT{1'b0}}});
    entry.z           = '0;
    entry.fl.r        = in_rad.r;
    entry.fl.neg      = in_rad.neg;
    entry.fl.straight = in_rad.straight;
    entry.fl.clip     = in_rad.clip;
    entry.fl.swap     = swap;
    entry.fl.zl       = (wheelbase == '0);
    entry.fl.zr       = (in_rad.r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd_r[0] <= entry;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_iter
    localparam logic signed [Z_W-1:0] T = Z_W'(tpsa_pkg::atan_q32(k));
    cd_stage_t              nxt;
    logic signed [CX_W-1:0] xs_o, ys_o;
    logic signed [Z_W-1:0]  z_o;

    assign xs_o = cd_r[k-1].xs;
    assign ys_o = cd_r[k-1].ys;
    assign z_o  = cd_r[k-1].z;

    always_comb begin
      nxt = cd_r[k-1];
      if (!ys_o[CX_W-1]) begin
        nxt.xs = xs_o + (ys_o >>> k);
        nxt.ys = ys_o - (xs_o >>> k);
        nxt.z  = z_o + T;
      end else begin
        nxt.xs = xs_o - (ys_o >>> k);
        nxt.ys = ys_o + (xs_o >>> k);
        nxt.z  = z_o - T;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cd_r[k] <= nxt;
      end
    end
  end

  // scale radians (Q32) to degrees
  logic                  vm_r;
  logic signed [63:0]    prod_r;
  flags_t                flm_r;
  logic signed [Z_W-1:0] z_last;

  assign z_last = cd_r[NS].z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(z_last) * tpsa_pkg::DEG_PER_RAD_Q24;
      flm_r  <= cd_r[NS].fl;
    end
  end

  // round, unfold the swap, clamp, apply the sign
  logic signed [63:0]                u0, u1, u2;
  logic [tpsa_pkg::ANG_W-1:0]        amag;
  logic [tpsa_pkg::RAD_W-1:0]        rmag;
  tpsa_pkg::result_t                 res_nxt, res_r;
  logic                              vf_r;

  always_comb begin
    u0 = (prod_r + tpsa_pkg::ANG_RND) >>> tpsa_pkg::ANG_SHIFT;
    u1 = flm_r.swap ? (64'(tpsa_pkg::ANG_FULL) - u0) : u0;
    if (u1 < 64'sd0) begin
      u2 = '0;
    end else if (u1 > 64'(tpsa_pkg::ANG_LIM)) begin
      u2 = 64'(tpsa_pkg::ANG_LIM);
    end else begin
      u2 = u1;
    end
    if (flm_r.zl) begin
      amag = '0;
    end else if (flm_r.zr) begin
      amag = tpsa_pkg::ANG_W'(tpsa_pkg::ANG_LIM);
    end else begin
      amag = u2[tpsa_pkg::ANG_W-1:0];
    end
    rmag = tpsa_pkg::RAD_W'(flm_r.r);
    if (flm_r.straight) begin
      res_nxt.turn_radius = tpsa_pkg::RADIUS_MAX;
      res_nxt.steer_angle = '0;
      res_nxt.straight    = 1'b1;
      res_nxt.clip        = 1'b0;
    end else begin
      res_nxt.turn_radius = flm_r.neg ? -rmag : rmag;
      res_nxt.steer_angle = flm_r.neg ? -amag : amag;
      res_nxt.straight    = 1'b0;
      res_nxt.clip        = flm_r.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vf_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

### sv/three_point_steering_angle.sv
// Top level: configuration register, pipeline flow control and result register.
`default_nettype none
// Three-point steering angle. Each transaction carries three path points and
// returns the signed circumradius in mm (saturated to 32 bits) and the
// bicycle-model front wheel angle in 1/256 degree. The block accepts one
// transaction per clock while in_stall is low. Stages: 7 geometry (area and
// the product of squared sides), 74 square-root (one root bit each), 32
// divider (clip test, 31 quotient bits), 35 CORDIC and scaling, and the
// result register. Bubbles are squeezed out while the result register is held
// by out_stall; in_stall rises only once a valid result sits in the last
// stage behind a held result. The wheelbase register at byte address 0 resets
// to 2570 mm; the user must write it only while idle, unchecked by the block.
module three_point_steering_angle (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [tpsa_pkg::COORD_BITS-1:0] in_ax_mm,
  input  logic signed [tpsa_pkg::COORD_BITS-1:0] in_ay_mm,
  input  logic signed [tpsa_pkg::COORD_BITS-1:0] in_bx_mm,
  input  logic signed [tpsa_pkg::COORD_BITS-1:0] in_by_mm,
  input  logic signed [tpsa_pkg::COORD_BITS-1:0] in_cx_mm,
  input  logic signed [tpsa_pkg::COORD_BITS-1:0] in_cy_mm,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tpsa_pkg::RAD_W-1:0]      out_turn_radius,
  output logic signed [tpsa_pkg::ANG_W-1:0]      out_steer_angle,
  output logic                                   out_straight_path,
  output logic                                   out_radius_clipped,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [2:0]                             cfg_paddr,
  input  logic [31:0]                            cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);

  logic [tpsa_pkg::WB_W-1:0] wb_r;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= tpsa_pkg::WHEELBASE_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == tpsa_pkg::REG_WHEELBASE)) begin
      wb_r <= cfg_pwdata[tpsa_pkg::WB_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      tpsa_pkg::REG_WHEELBASE: cfg_prdata = 32'(wb_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // flow control: advance whenever the last stage can move on
  logic              en, out_take, last_valid;
  logic              out_valid_r;
  tpsa_pkg::result_t out_r, last_res;

  assign out_take = !out_valid_r || !out_stall;
  assign en       = out_take || !last_valid;
  assign in_stall = !en;

  logic            g_valid, s_valid, d_valid;
  tpsa_pkg::geom_t g_data;
  tpsa_pkg::root_t s_data;
  tpsa_pkg::rad_t  d_data;

  tpsa_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .ax        (in_ax_mm),
    .ay        (in_ay_mm),
    .bx        (in_bx_mm),
    .by        (in_by_mm),
    .cx        (in_cx_mm),
    .cy        (in_cy_mm),
    .out_valid (g_valid),
    .out_geom  (g_data)
  );

  tpsa_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (g_valid),
    .in_geom   (g_data),
    .out_valid (s_valid),
    .out_root  (s_data)
  );

  tpsa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .in_root   (s_data),
    .out_valid (d_valid),
    .out_rad   (d_data)
  );

  tpsa_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid),
    .in_rad    (d_data),
    .wheelbase (wb_r),
    .out_valid (last_valid),
    .out_res   (last_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_r <= last_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_turn_radius    = out_r.turn_radius;
  assign out_steer_angle    = out_r.steer_angle;
  assign out_straight_path  = out_r.straight;
  assign out_radius_clipped = out_r.clip;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && last_valid))
    else $error("input held back without a blocked result");

  a_straight_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_straight_path) |->
      (out_turn_radius == 32'sh7FFF_FFFF && out_steer_angle == 16'sd0 &&
       !out_radius_clipped))
    else $error("straight path with a bent result");

  a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_radius_clipped) |->
      (out_turn_radius == 32'sh7FFF_FFFF || out_turn_radius == -32'sh7FFF_FFFF))
    else $error("clipped radius not at the limit");

  a_angle_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_turn_radius < 0) |->
      (out_steer_angle <= 0 && out_steer_angle >= -16'sd23040))
    else $error("angle sign does not follow radius");

endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the three-point steering angle block.
module tb_top;

  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 160;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] WHEELBASE_ADDR = {1'b0, tpsa_pkg::REG_WHEELBASE, 1'b0} << 1;

  typedef struct {
    logic signed [tpsa_pkg::RAD_W-1:0] radius;
    logic signed [tpsa_pkg::ANG_W-1:0] angle;
    logic straight;
    logic clipped;
  } steer_result_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [tpsa_pkg::COORD_BITS-1:0] in_ax_mm, in_ay_mm, in_bx_mm;
  logic signed [tpsa_pkg::COORD_BITS-1:0] in_by_mm, in_cx_mm, in_cy_mm;
  logic signed [tpsa_pkg::RAD_W-1:0] out_turn_radius;
  logic signed [tpsa_pkg::ANG_W-1:0] out_steer_angle;
  logic out_straight_path, out_radius_clipped;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  steer_result_t expected_q[$];
  logic [tpsa_pkg::WB_W-1:0] wheelbase_shadow;
  int errors, checked, sent, idle_cycles;
  int clipped_seen, straight_seen;
  bit tx_gaps, rx_gaps;
  int hold_requests, holds_served, hold_left;

  three_point_steering_angle uut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // atan(2^-i) in Q32 radians
  function automatic longint atan_step(input int i);
    longint unsigned sum;
    longint unsigned term;
    int e;
    sum = 0;
    for (int k = 0; k < 32; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e >= 0) begin
        term = (64'd1 << e) / longint'(2 * k + 1);
        if (k % 2 == 1) sum = sum - term;
        else            sum = sum + term;
      end
    end
    return longint'((sum + (64'd1 << 29)) >> 30);
  endfunction

  function automatic longint steer_mag(input longint r, input longint wb);
    longint full, lim, big, lil, xs, ys, z, dx, dy, u;
    bit swap;
    full = longint'(90) << tpsa_pkg::ANGLE_FRAC_BITS;
    lim = (full < 32767) ? full : 32767;
    if (wb == 0) return 0;
    if (r == 0) return lim;
    swap = wb > r;
    big = swap ? wb : r;
    lil = swap ? r : wb;
    xs = big << 24;
    ys = lil << 24;
    z = 0;
    for (int i = 1; i <= 32; i++) begin
      dx = ys >>> i;
      dy = xs >>> i;
      if (ys >= 0) begin
        xs = xs + dx; ys = ys - dy; z = z + atan_step(i);
      end else begin
        xs = xs - dx; ys = ys + dy; z = z - atan_step(i);
      end
    end
    u = (z * 64'sd961263669 + (64'sd1 <<< (55 - tpsa_pkg::ANGLE_FRAC_BITS)))
        >>> (56 - tpsa_pkg::ANGLE_FRAC_BITS);
    if (swap) u = full - u;
    if (u < 0) u = 0;
    if (u > lim) u = lim;
    return u;
  endfunction

  function automatic logic [255:0] side_sq(input longint dx, input longint dy);
    logic [255:0] ux, uy;
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    return ux * ux + uy * uy;
  endfunction

  function automatic steer_result_t predict_steering(
      input logic signed [tpsa_pkg::COORD_BITS-1:0] ax, ay, bx, by, cx, cy,
      input logic [tpsa_pkg::WB_W-1:0] wb);
    steer_result_t res;
    longint pax, pay, pbx, pby, pcx, pcy, area2, xm, r, ang;
    logic [255:0] p, dd, t, c;
    bit neg;
    pax = ax; pay = ay; pbx = bx; pby = by; pcx = cx; pcy = cy;
    area2 = (pax - pcx) * (pby - pcy) - (pbx - pcx) * (pay - pcy);
    if (area2 == 0) begin
      res.radius = tpsa_pkg::RADIUS_MAX;
      res.angle = '0;
      res.straight = 1'b1;
      res.clipped = 1'b0;
      return res;
    end
    neg = area2 < 0;
    xm = neg ? -area2 : area2;
    p = side_sq(pax - pbx, pay - pby) * side_sq(pax - pcx, pay - pcy)
        * side_sq(pbx - pcx, pby - pcy);
    dd = 256'(xm) << 1;
    t = dd << 31;
    r = 0;
    res.clipped = 1'b0;
    if (t * t <= p) begin
      res.clipped = 1'b1;
      r = 64'h7FFF_FFFF;
    end else begin
      for (int b = 30; b >= 0; b--) begin
        c = 256'(r) | (256'd1 << b);
        t = dd * c;
        if (t * t <= p) r = longint'(c);
      end
    end
    ang = steer_mag(r, longint'(wb));
    res.radius = neg ? tpsa_pkg::RAD_W'(-r) : tpsa_pkg::RAD_W'(r);
    res.angle = neg ? tpsa_pkg::ANG_W'(-ang) : tpsa_pkg::ANG_W'(ang);
    res.straight = 1'b0;
    return res;
  endfunction

  // Receiver: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      holds_served <= 0;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_gaps && ($urandom_range(99) < 32);
    end
  end

  // Compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    steer_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: radius %0d", $time, out_turn_radius);
        errors++;
      end else begin
        e = expected_q.pop_front();
        checked++;
        if (out_turn_radius !== e.radius) begin
          $display("%0t: turn_radius expected %0d actual %0d", $time, e.radius,
                   out_turn_radius);
          errors++;
        end
        if (out_steer_angle !== e.angle) begin
          $display("%0t: steer_angle expected %0d actual %0d", $time, e.angle,
                   out_steer_angle);
          errors++;
        end
        if (out_straight_path !== e.straight) begin
          $display("%0t: straight_path expected %0b actual %0b", $time, e.straight,
                   out_straight_path);
          errors++;
        end
        if (out_radius_clipped !== e.clipped) begin
          $display("%0t: radius_clipped expected %0b actual %0b", $time, e.clipped,
                   out_radius_clipped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("%0t: no progress, %0d results outstanding", $time, expected_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_points(
      input logic signed [tpsa_pkg::COORD_BITS-1:0] ax, ay, bx, by, cx, cy);
    steer_result_t e;
    // idle each cycle with the same odds
    while (tx_gaps && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ax_mm <= ax; in_ay_mm <= ay;
    in_bx_mm <= bx; in_by_mm <= by;
    in_cx_mm <= cx; in_cy_mm <= cy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = predict_steering(ax, ay, bx, by, cx, cy, wheelbase_shadow);
    if (e.clipped) clipped_seen++;
    if (e.straight) straight_seen++;
    expected_q.push_back(e);
    sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_wheelbase(input logic [tpsa_pkg::WB_W-1:0] wb);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= WHEELBASE_ADDR; cfg_pwdata <= 32'(wb);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    wheelbase_shadow = wb;
    @(posedge clk);
  endtask

  task automatic random_triangle;
    logic signed [tpsa_pkg::COORD_BITS-1:0] ax, ay, bx, by, cx, cy;
    int span, mode, k;
    mode = $urandom_range(99);
    span = $urandom_range(1, 20);
    ax = $urandom; ay = $urandom;
    if (mode < 20) begin
      bx = $urandom; by = $urandom; cx = $urandom; cy = $urandom;
    end else if (mode < 70) begin
      bx = ax + $signed(($urandom & ((1 << span + 1) - 1)) - (1 << span));
      by = ay + $signed(($urandom & ((1 << span + 1) - 1)) - (1 << span));
      cx = ax + $signed(($urandom & ((1 << span + 1) - 1)) - (1 << span));
      cy = ay + $signed(($urandom & ((1 << span + 1) - 1)) - (1 << span));
    end else if (mode < 85) begin
      // collinear: equal steps along one direction
      bx = $signed(($urandom & ((1 << span + 1) - 1)) - (1 << span));
      by = $signed(($urandom & ((1 << span + 1) - 1)) - (1 << span));
      k = $urandom_range(0, 3) - 1;
      cx = ax + k * bx; cy = ay + k * by;
      bx = ax + bx; by = ay + by;
    end else begin
      // nearly collinear, then nudge the last point by up to two millimetres per axis
      bx = $signed(($urandom & ((1 << span + 1) - 1)) - (1 << span));
      by = $signed(($urandom & ((1 << span + 1) - 1)) - (1 << span));
      cx = ax + 2 * bx + $signed($urandom_range(0, 4)) - 2;
      cy = ay + 2 * by + $signed($urandom_range(0, 4)) - 2;
      bx = ax + bx; by = ay + by;
    end
    send_points(ax, ay, bx, by, cx, cy);
  endtask

  task automatic test_directed;
    localparam logic signed [tpsa_pkg::COORD_BITS-1:0] MAXC = 24'sh7FFFFF;
    localparam logic signed [tpsa_pkg::COORD_BITS-1:0] MINC = 24'sh800000;
    tx_gaps = 0; rx_gaps = 0;
    send_points(0, 0, 1, 0, 0, 1);               // radius under a millimetre, left
    send_points(0, 0, 0, 1, 1, 0);               // same, right turn
    send_points(0, 0, 1000, 0, 0, 1000);
    send_points(0, 0, 1000, 0, 1000, 0);         // coincident points
    send_points(5, 5, 5, 5, 5, 5);               // all points equal
    send_points(-10, -10, 0, 0, 10, 10);         // collinear
    send_points(MINC, 0, MAXC, 0, 0, 1);         // radius overflow
    send_points(MINC, 0, MAXC, 0, 0, -1);
    send_points(MINC, MINC, MAXC, MAXC, MINC, MAXC);
    send_points(MAXC, MAXC, MINC, MINC, MAXC, MINC);
    send_points(MAXC, MINC, MINC, MAXC, MINC, MINC);
    send_points(MAXC, MAXC, MAXC, MINC, MINC, MAXC);
    send_points(0, 0, 2570, 0, 2570, 2570);      // radius near the wheelbase
    send_points(0, 0, 100000, 0, 50000, 3000);
    send_points(-1, -1, -1, 0, 0, -1);
    send_points(24'sh555555, 24'shAAAAAA, 24'sh2AAAAA, 24'sh555555, 24'shD55555, 0);
    drain();
  endtask

  task automatic test_random(input int count, input logic [tpsa_pkg::WB_W-1:0] wb);
    write_wheelbase(wb);
    tx_gaps = 1; rx_gaps = 1;
    for (int n = 0; n < count; n++) random_triangle();
    drain();
  endtask

  task automatic test_no_gaps(input int count);
    tx_gaps = 0; rx_gaps = 0;
    for (int n = 0; n < count; n++) random_triangle();
    drain();
  endtask

  task automatic test_backpressure(input int count);
    tx_gaps = 0; rx_gaps = 0;
    hold_requests++;
    for (int n = 0; n < count; n++) random_triangle();
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; out_stall = 1'b0;
    in_ax_mm = '0; in_ay_mm = '0; in_bx_mm = '0;
    in_by_mm = '0; in_cx_mm = '0; in_cy_mm = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    errors = 0; checked = 0; sent = 0; idle_cycles = 0;
    clipped_seen = 0; straight_seen = 0;
    hold_requests = 0; tx_gaps = 0; rx_gaps = 0;
    wheelbase_shadow = tpsa_pkg::WHEELBASE_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(100, tpsa_pkg::WHEELBASE_RESET);
    test_random(60, 16'd1);
    test_random(60, 16'hFFFF);
    test_random(30, 16'd0);
    test_random(70, 16'($urandom_range(1, 65535)));
    test_no_gaps(60);
    test_backpressure(200);
    test_random(30, 16'd2570);

    repeat (DRAIN_CYCLES) @(posedge clk);
    errors += expected_q.size();
    $display("Sent %0d point triples across five distinct wheelbase values, %0d checked,",
             sent, checked);
    $display("%0d straight paths, %0d clipped radii, one long receiver hold.",
             straight_seen, clipped_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/tpsa_pkg.sv
sv/tpsa_geom.sv
sv/tpsa_sqrt.sv
sv/tpsa_div.sv
sv/tpsa_cordic.sv
sv/three_point_steering_angle.sv
sim/tb_top.sv
